// File: sv/csvtok_pkg.sv
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared types and character codes for the CSV record tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_CELL   = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_DONE   = 2'd3
    } token_kind_t;

    localparam int DELIM_BITS = 16;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [DELIM_BITS-1:0] DELIM_RESET = 16'h002C;

endpackage

// File: sv/csv_record_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// Splits a character stream into append, end-cell, end-record and done tokens.
// ----------------------------------------------------------------------------
// One character enters per cycle while char_stall is low. An item is held in
// an input register and decoded against the three parser flags; its tokens go
// into an output register that downstream drains. Most items give one token,
// so the block sustains one item per clock while token_stall is low. An
// end-of-text item with a record still open gives an end of record and then
// done, holding the input register until both are out; the LF of a CR LF pair
// gives no token. The delimiter must be written through delimiter_we only
// while the block is idle, not enforced by the block. It resets to a comma.
module csv_record_tokenizer #(
    parameter int CHAR_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               delimiter_we,
    input  logic [csvtok_pkg::DELIM_BITS-1:0]  delimiter_char,
    input  logic                               char_valid,
    output logic                               char_stall,
    input  logic [CHAR_BITS-1:0]               char_code,
    input  logic                               end_of_text,
    output logic                               token_valid,
    input  logic                               token_stall,
    output logic [1:0]                         token_kind,
    output logic [CHAR_BITS-1:0]               out_char,
    output logic                               last_of_run
);

    logic [csvtok_pkg::DELIM_BITS-1:0] delim_reg;

    logic                 item_valid_reg;
    logic [CHAR_BITS-1:0] item_char_reg;
    logic                 item_end_reg;
    logic                 phase_reg;

    logic in_quotes_reg,      in_quotes_next;
    logic record_pending_reg, record_pending_next;
    logic after_bare_cr_reg,  after_bare_cr_next;

    logic                    tok_valid_reg;
    csvtok_pkg::token_kind_t tok_kind_reg;
    logic [CHAR_BITS-1:0]    tok_char_reg;
    logic                    tok_last_reg;

    // decode of the held item
    logic                    two_res;
    logic                    no_res;
    csvtok_pkg::token_kind_t kind0;
    logic                    is_quote, is_lf, is_cr, is_delim;
    logic                    out_ok, emit, item_done, take_in;
    csvtok_pkg::token_kind_t emit_kind;
    logic                    emit_last;

    assign is_quote = item_char_reg == CHAR_BITS'(csvtok_pkg::CH_QUOTE);
    assign is_lf    = item_char_reg == CHAR_BITS'(csvtok_pkg::CH_LF);
    assign is_cr    = item_char_reg == CHAR_BITS'(csvtok_pkg::CH_CR);
    assign is_delim = item_char_reg == CHAR_BITS'(delim_reg);

    always_comb
    begin
        two_res             = 1'b0;
        no_res              = 1'b0;
        kind0               = csvtok_pkg::KIND_APPEND;
        in_quotes_next      = in_quotes_reg;
        record_pending_next = 1'b1;
        after_bare_cr_next  = 1'b0;
        if (item_end_reg)
        begin
            two_res             = record_pending_reg;
            kind0               = record_pending_reg ? csvtok_pkg::KIND_RECORD
                                                     : csvtok_pkg::KIND_DONE;
            in_quotes_next      = 1'b0;
            record_pending_next = 1'b0;
        end
        else if (is_quote)
        begin
            in_quotes_next = !in_quotes_reg;
        end
        else if (!in_quotes_reg && (is_lf || is_cr))
        begin
            if (is_lf && after_bare_cr_reg)
            begin
                // drop the LF of a CR LF pair
                no_res              = 1'b1;
                record_pending_next = record_pending_reg;
            end
            else
            begin
                kind0               = csvtok_pkg::KIND_RECORD;
                record_pending_next = 1'b0;
                after_bare_cr_next  = is_cr;
            end
        end
        else if (!in_quotes_reg && is_delim)
        begin
            kind0 = csvtok_pkg::KIND_CELL;
        end
    end

    assign out_ok    = !tok_valid_reg || !token_stall;
    assign emit      = item_valid_reg && !no_res && out_ok;
    assign emit_kind = phase_reg ? csvtok_pkg::KIND_DONE : kind0;
    assign emit_last = phase_reg || !two_res;
    assign item_done = item_valid_reg && (no_res || (out_ok && emit_last));
    assign char_stall = item_valid_reg && !item_done;
    assign take_in   = char_valid && !char_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg          <= csvtok_pkg::DELIM_RESET;
            item_valid_reg     <= 1'b0;
            phase_reg          <= 1'b0;
            in_quotes_reg      <= 1'b0;
            record_pending_reg <= 1'b0;
            after_bare_cr_reg  <= 1'b0;
            tok_valid_reg      <= 1'b0;
        end
        else
        begin
            if (delimiter_we)
                delim_reg <= delimiter_char;

            if (take_in)
                item_valid_reg <= 1'b1;
            else if (item_done)
                item_valid_reg <= 1'b0;

            // advance to the second token of an end item
            if (item_done)
                phase_reg <= 1'b0;
            else if (emit)
                phase_reg <= 1'b1;

            if (item_done)
            begin
                in_quotes_reg      <= in_quotes_next;
                record_pending_reg <= record_pending_next;
                after_bare_cr_reg  <= after_bare_cr_next;
            end

            if (emit)
                tok_valid_reg <= 1'b1;
            else if (!token_stall)
                tok_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_char_reg <= char_code;
            item_end_reg  <= end_of_text;
        end
        if (emit)
        begin
            tok_kind_reg <= emit_kind;
            tok_char_reg <= (emit_kind == csvtok_pkg::KIND_APPEND) ? item_char_reg
                                                                   : '0;
            tok_last_reg <= emit_last;
        end
    end

    assign token_valid = tok_valid_reg;
    assign token_kind  = tok_kind_reg;
    assign out_char    = tok_char_reg;
    assign last_of_run = tok_last_reg;

endmodule

// File: sv/csvtok_checker.sv
// ----------------------------------------------------------------------------
// csvtok_checker
// Port-level checks for the CSV record tokenizer, bound to each instance.
// ----------------------------------------------------------------------------
module csvtok_checker #(
    parameter int CHAR_BITS = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 token_valid,
    input logic                 token_stall,
    input logic [1:0]           token_kind,
    input logic [CHAR_BITS-1:0] out_char,
    input logic                 last_of_run
);

    // hold a stalled token
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_kind)
            && $stable(out_char) && $stable(last_of_run))
        else $error("stalled token changed");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == csvtok_pkg::KIND_DONE |-> last_of_run)
        else $error("done token not last of run");

    a_only_record_leads: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !last_of_run |-> token_kind == csvtok_pkg::KIND_RECORD)
        else $error("non-final token is not an end of record");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind != csvtok_pkg::KIND_APPEND |-> out_char == '0)
        else $error("character set on a non-append token");

endmodule

bind csv_record_tokenizer csvtok_checker #(.CHAR_BITS(CHAR_BITS)) u_csvtok_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_kind  (token_kind),
    .out_char    (out_char),
    .last_of_run (last_of_run)
);

// File: bench/csv_record_tokenizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_record_tokenizer_checker
// Watches both channels of the tokenizer, predicts its tokens and compares.
// ----------------------------------------------------------------------------
// Every accepted character runs through a local copy of the parser flags and
// the delimiter and leaves its expected tokens in a queue. Every accepted token
// is compared field by field with the oldest entry. Delimiter writes are seen
// on the configuration port and applied to the local copy.
module csv_record_tokenizer_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               delimiter_we,
    input  logic [csvtok_pkg::DELIM_BITS-1:0]  delimiter_char,
    input  logic                               char_valid,
    input  logic                               char_stall,
    input  logic [15:0]                        char_code,
    input  logic                               end_of_text,
    input  logic                               token_valid,
    input  logic                               token_stall,
    input  logic [1:0]                         token_kind,
    input  logic [15:0]                        out_char,
    input  logic                               last_of_run,
    output int                                 mismatch_count,
    output int                                 tokens_pending,
    output int                                 tokens_seen
);

    localparam logic [15:0] QUOTE_CODE = {8'h00, csvtok_pkg::CH_QUOTE};
    localparam logic [15:0] LF_CODE    = {8'h00, csvtok_pkg::CH_LF};
    localparam logic [15:0] CR_CODE    = {8'h00, csvtok_pkg::CH_CR};

    typedef struct packed {
        csvtok_pkg::token_kind_t kind;
        logic [15:0]             chr;
        logic                    last;
    } token_t;

    token_t                              expected_tokens[$];
    logic [csvtok_pkg::DELIM_BITS-1:0]   delim_q;
    logic                                in_quotes;
    logic                                record_open;
    logic                                after_cr;

    task automatic push_token(input csvtok_pkg::token_kind_t kind,
                              input logic [15:0] chr, input logic last);
        token_t tk;
        tk.kind = kind;
        tk.chr  = chr;
        tk.last = last;
        expected_tokens.insert(expected_tokens.size(), tk);
    endtask

    task automatic predict_tokens(input logic [15:0] code, input logic eot);
        if (eot)
        begin
            if (record_open)
                push_token(csvtok_pkg::KIND_RECORD, '0, 1'b0);
            push_token(csvtok_pkg::KIND_DONE, '0, 1'b1);
            // forget any unclosed quote
            in_quotes   = 1'b0;
            record_open = 1'b0;
            after_cr    = 1'b0;
        end
        else if (code == QUOTE_CODE)
        begin
            push_token(csvtok_pkg::KIND_APPEND, code, 1'b1);
            in_quotes   = !in_quotes;
            record_open = 1'b1;
            after_cr    = 1'b0;
        end
        else if (!in_quotes && (code == LF_CODE || code == CR_CODE))
        begin
            // drop the LF of a CRLF pair
            if (code == LF_CODE && after_cr)
                after_cr = 1'b0;
            else
            begin
                push_token(csvtok_pkg::KIND_RECORD, '0, 1'b1);
                record_open = 1'b0;
                after_cr    = (code == CR_CODE);
            end
        end
        else if (!in_quotes && code == delim_q)
        begin
            push_token(csvtok_pkg::KIND_CELL, '0, 1'b1);
            record_open = 1'b1;
            after_cr    = 1'b0;
        end
        else
        begin
            push_token(csvtok_pkg::KIND_APPEND, code, 1'b1);
            record_open = 1'b1;
            after_cr    = 1'b0;
        end
    endtask

    task automatic compare_token();
        token_t want;
        tokens_seen++;
        if (expected_tokens.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected token kind %0d char %h last %b", $realtime,
                         token_kind, out_char, last_of_run);
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (token_kind !== want.kind || out_char !== want.chr
                || last_of_run !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: token %0d expected kind %0d char %h last %b, got %0d %h %b",
                             $realtime, tokens_seen, want.kind, want.chr, want.last,
                             token_kind, out_char, last_of_run);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_tokens.delete();
            delim_q        = csvtok_pkg::DELIM_RESET;
            in_quotes      = 1'b0;
            record_open    = 1'b0;
            after_cr       = 1'b0;
            mismatch_count = 0;
            tokens_pending = 0;
            tokens_seen    = 0;
        end
        else
        begin
            if (delimiter_we)
                delim_q = delimiter_char;
            if (token_valid && !token_stall)
                compare_token();
            if (char_valid && !char_stall)
                predict_tokens(char_code, end_of_text);
            tokens_pending = expected_tokens.size();
        end
    end

endmodule

// File: bench/csv_record_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_record_tokenizer_tb
// Stimulus and verdict for the CSV record tokenizer.
// ----------------------------------------------------------------------------
// A directed opening covers quoting, CRLF handling and end of text; then a
// series of delimiter settings each gets a run of mostly CSV-shaped random
// text with noise. Both channels idle in random bursts, the output is held off
// once for a long stretch, and the final setting runs at full rate.
module csv_record_tokenizer_tb;

    localparam int          CHAR_BITS  = 16;
    localparam int          PHASES     = 10;
    localparam int          PHASE_ITEMS = 182;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [15:0] QUOTE_CODE = {8'h00, csvtok_pkg::CH_QUOTE};
    localparam logic [15:0] LF_CODE    = {8'h00, csvtok_pkg::CH_LF};
    localparam logic [15:0] CR_CODE    = {8'h00, csvtok_pkg::CH_CR};
    localparam logic [15:0] COMMA_CODE = csvtok_pkg::DELIM_RESET;

    logic                               clk            = 1'b0;
    logic                               rst_n          = 1'b0;
    logic                               delimiter_we   = 1'b0;
    logic [csvtok_pkg::DELIM_BITS-1:0]  delimiter_char = csvtok_pkg::DELIM_RESET;
    logic                               char_valid     = 1'b0;
    logic                               char_stall;
    logic [CHAR_BITS-1:0]               char_code      = '0;
    logic                               end_of_text    = 1'b0;
    logic                               token_valid;
    logic                               token_stall    = 1'b0;
    logic [1:0]                         token_kind;
    logic [CHAR_BITS-1:0]               out_char;
    logic                               last_of_run;

    int                     mismatch_count;
    int                     tokens_pending;
    int                     tokens_seen;

    bit                     calm         = 1'b0;
    int                     hold_request = 0;
    int                     gap_pct      = 0;
    int                     chars_sent   = 0;
    int                     ends_sent    = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    csv_record_tokenizer #(
        .CHAR_BITS(CHAR_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .delimiter_we  (delimiter_we),
        .delimiter_char(delimiter_char),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_code     (char_code),
        .end_of_text   (end_of_text),
        .token_valid   (token_valid),
        .token_stall   (token_stall),
        .token_kind    (token_kind),
        .out_char      (out_char),
        .last_of_run   (last_of_run)
    );

    csv_record_tokenizer_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .delimiter_we  (delimiter_we),
        .delimiter_char(delimiter_char),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_code     (char_code),
        .end_of_text   (end_of_text),
        .token_valid   (token_valid),
        .token_stall   (token_stall),
        .token_kind    (token_kind),
        .out_char      (out_char),
        .last_of_run   (last_of_run),
        .mismatch_count(mismatch_count),
        .tokens_pending(tokens_pending),
        .tokens_seen   (tokens_seen)
    );

    // Offer one item and hold it until the transfer; an optional idle gap first.
    task automatic send_item(input logic [15:0] code, input logic eot);
        bit taken;
        if (!calm && $urandom_range(1, 100) <= gap_pct)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        char_valid  <= 1'b1;
        char_code   <= code;
        end_of_text <= eot;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !char_stall;
            @(posedge clk);
        end
        if (eot)
            ends_sent++;
        else
            chars_sent++;
    endtask

    // Wait until every token is out, then let a dropped LF clear the pipe.
    task automatic drain_tokens();
        char_valid <= 1'b0;
        do
            @(negedge clk);
        while (tokens_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_delimiter(input logic [15:0] value);
        delimiter_we   <= 1'b1;
        delimiter_char <= value;
        @(posedge clk);
        delimiter_we   <= 1'b0;
    endtask

    // Mostly CSV-shaped text for the current delimiter, with some noise.
    task automatic send_random_text(input logic [15:0] delim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            send_item(16'($urandom_range(16'h20, 16'h7E)), 1'b0);
        else if (r < 45)
            send_item(16'($urandom_range(0, 16'hFFFF)), 1'b0);
        else if (r < 58)
            send_item(delim, 1'b0);
        else if (r < 68)
            send_item(QUOTE_CODE, 1'b0);
        else if (r < 76)
        begin
            send_item(CR_CODE, 1'b0);
            if ($urandom_range(0, 1))
                send_item(LF_CODE, 1'b0);
        end
        else if (r < 82)
            send_item(LF_CODE, 1'b0);
        else if (r < 84)
            send_item(16'($urandom_range(0, 16'hFFFF)), 1'b1);
        else if (r < 92)
        begin
            // special low byte under a nonzero high byte is plain text
            case ($urandom_range(0, 2))
                0: send_item({8'($urandom_range(1, 255)), csvtok_pkg::CH_QUOTE}, 1'b0);
                1: send_item({8'($urandom_range(1, 255)), csvtok_pkg::CH_CR}, 1'b0);
                default: send_item({8'($urandom_range(1, 255)), csvtok_pkg::CH_LF}, 1'b0);
            endcase
        end
        else
            send_item($urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 1'b0);
    endtask

    initial
    begin : token_sink
        int stretch;
        int busy_pct;
        stretch  = 0;
        busy_pct = 0;
        forever
        begin
            @(posedge clk);
            if (stretch == 0)
            begin
                stretch = $urandom_range(40, 250);
                case ($urandom_range(0, 2))
                    0: busy_pct = 0;
                    1: busy_pct = 15;
                    default: busy_pct = 50;
                endcase
            end
            stretch--;
            if (hold_request > 0)
            begin
                token_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                token_stall <= 1'b0;
            end
            else if (rst_n && !calm && $urandom_range(1, 100) <= busy_pct)
            begin
                token_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                token_stall <= 1'b0;
            end
            else
                token_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        logic [15:0] delim_values[PHASES];
        int          sent;
        delim_values = '{COMMA_CODE, 16'h0000, 16'hFFFF, QUOTE_CODE, CR_CODE, LF_CODE,
                         16'h003B, 16'h0009, 16'($urandom_range(0, 16'hFFFF)), COMMA_CODE};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening, reset delimiter
        gap_pct = 20;
        send_item(16'h0061, 1'b0);
        send_item(COMMA_CODE, 1'b0);
        send_item(QUOTE_CODE, 1'b0);
        send_item(COMMA_CODE, 1'b0);
        send_item(CR_CODE, 1'b0);
        send_item(QUOTE_CODE, 1'b0);
        send_item(QUOTE_CODE, 1'b0);
        send_item(QUOTE_CODE, 1'b0);
        send_item(CR_CODE, 1'b0);
        send_item(LF_CODE, 1'b0);
        send_item(LF_CODE, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(COMMA_CODE, 1'b0);
        send_item(QUOTE_CODE, 1'b1);
        send_item(16'h0000, 1'b1);
        send_item(QUOTE_CODE, 1'b0);
        send_item(16'h007A, 1'b0);
        send_item(16'hFFFF, 1'b1);
        send_item(COMMA_CODE, 1'b0);
        send_item(CR_CODE, 1'b0);
        send_item(16'h0000, 1'b1);
        send_item(CR_CODE, 1'b0);
        send_item(16'hFFFF, 1'b1);
        send_item(LF_CODE, 1'b0);
        send_item(16'h0000, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_tokens();
            write_delimiter(delim_values[p]);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 30;
            endcase
            if (p == PHASES - 1)
                calm = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // long output hold while the input keeps offering
                if (p == 1 && sent == 30)
                    hold_request = HOLD_CYCLES;
                send_random_text(delim_values[p]);
                sent++;
            end
        end

        drain_tokens();
        repeat (10) @(posedge clk);
        $display("Covered %0d characters and %0d end-of-text items over %0d delimiter settings,",
                 chars_sent, ends_sent, PHASES);
        $display("with quoting, CRLF pairs and a %0d-cycle output hold; %0d tokens checked.",
                 HOLD_CYCLES, tokens_seen);
        if (mismatch_count == 0 && tokens_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/csvtok_pkg.sv
sv/csv_record_tokenizer.sv
sv/csvtok_checker.sv
bench/csv_record_tokenizer_checker.sv
bench/csv_record_tokenizer_tb.sv
